// ----- sv/laser_scan_gap_finder_defines.svh -----
// assertion macros for the laser scan gap finder
`ifndef LASER_SCAN_GAP_FINDER_DEFINES_SVH
`define LASER_SCAN_GAP_FINDER_DEFINES_SVH

// checked outside reset
`define LSGF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define LSGF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- sv/lsgf_pkg.sv -----
// shared types and constants of the laser scan gap finder
`timescale 1ns / 1ps

package lsgf_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int MAX_OBJECTS = 32;

  localparam int RANGE_W   = 17;
  localparam int INDEX_W   = $clog2(MAX_SAMPLES);
  localparam int SLOT_W    = $clog2(MAX_OBJECTS);
  localparam int COUNT_W   = $clog2(MAX_OBJECTS + 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 17;

  typedef logic [RANGE_W-1:0] range_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [COUNT_W-1:0] count_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_RETURN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_START     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_END       = 2'd3;

  localparam range_t RST_JUMP_THRESHOLD = 17'd100;
  localparam range_t RST_NO_RETURN      = 17'd100000;
  localparam logic [9:0] RST_WRAP_START = 10'd34;
  localparam logic [9:0] RST_WRAP_END   = 10'd711;

  typedef struct packed {
    index_t start_idx;
    range_t start_rng;
    index_t end_idx;
    range_t end_rng;
  } obj_entry_t;

  typedef struct packed {
    logic       we;
    slot_t      addr;
    obj_entry_t entry;
  } mem_wr_t;

  typedef struct packed {
    logic  en;
    slot_t addr_a;
    slot_t addr_b;
  } mem_rd_t;

endpackage

// ----- sv/lsgf_channels.sv -----
// handshake channels for scan samples and gap results
`timescale 1ns / 1ps

interface lsgf_sample_if import lsgf_pkg::*; ();
  logic   valid;
  logic   ready;
  range_t range_mm;
  logic   no_return;
  logic   last_sample;

  modport source (output valid, output range_mm, output no_return, output last_sample,
                  input ready);
  modport sink (input valid, input range_mm, input no_return, input last_sample,
                output ready);
endinterface

interface lsgf_gap_if import lsgf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [9:0] gap_start_index;
  range_t     gap_start_range_mm;
  logic [9:0] gap_end_index;
  range_t     gap_end_range_mm;
  logic       no_objects;
  logic       table_overflow;
  logic       last_gap;

  modport source (output valid, output gap_start_index, output gap_start_range_mm,
                  output gap_end_index, output gap_end_range_mm, output no_objects,
                  output table_overflow, output last_gap, input ready);
  modport sink (input valid, input gap_start_index, input gap_start_range_mm,
                input gap_end_index, input gap_end_range_mm, input no_objects,
                input table_overflow, input last_gap, output ready);
endinterface

// ----- sv/lsgf_obj_mem.sv -----
// object table memory, one write port and two registered read ports
`timescale 1ns / 1ps

module lsgf_obj_mem import lsgf_pkg::*; (
  input  logic       clk_i,
  input  mem_wr_t    wr_i,
  input  mem_rd_t    rd_i,
  output obj_entry_t rd_a_o,
  output obj_entry_t rd_b_o
);

  obj_entry_t mem_q [MAX_OBJECTS];
  obj_entry_t rd_a_q;
  obj_entry_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_a_q <= mem_q[rd_i.addr_a];
      rd_b_q <= mem_q[rd_i.addr_b];
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

// ----- sv/laser_scan_gap_finder.sv -----
// laser scan gap finder: jump segmentation, object table and gap output
// non-final samples are taken one sample per cycle; input is held off outside the run state
// on the final sample: a close state ends the last run, then each gap takes an emit
//   state (table read) and a load state (output load), and waits while the output is stalled
// throughput is set by the single output register and the registered table read
// reset clears all control state and loads the register defaults; the table is not cleared
`timescale 1ns / 1ps
`include "laser_scan_gap_finder_defines.svh"

module laser_scan_gap_finder import lsgf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  lsgf_sample_if.sink          sample_i,
  lsgf_gap_if.source           gap_o
);

  typedef enum logic [1:0] {
    S_RUN,
    S_CLOSE,
    S_EMIT,
    S_LOAD
  } state_e;

  state_e     state_q, state_d;
  range_t     thr_q, thr_d;
  range_t     nr_q, nr_d;
  logic [9:0] wst_q, wst_d;
  logic [9:0] wen_q, wen_d;

  index_t     cnt_q, cnt_d;
  range_t     prev_q, prev_d;
  index_t     rs_idx_q, rs_idx_d;
  range_t     rs_rng_q, rs_rng_d;
  logic       rhr_q, rhr_d;
  count_t     obj_cnt_q, obj_cnt_d;
  logic       ovf_q, ovf_d;
  index_t     last_idx_q, last_idx_d;
  index_t     first_start_q, first_start_d;
  index_t     first_end_idx_q, first_end_idx_d;
  range_t     first_end_rng_q, first_end_rng_d;
  index_t     last_end_q, last_end_d;

  count_t     em_n_q, em_n_d;
  count_t     em_k_q, em_k_d;
  logic       em_base_q, em_base_d;
  logic       em_ovf_q, em_ovf_d;
  logic       em_merge_q, em_merge_d;
  logic       sub_q, sub_d;

  logic       out_valid_q, out_valid_d;
  obj_entry_t out_q, out_d;
  logic       out_noobj_q, out_noobj_d;
  logic       out_ovf_q, out_ovf_d;
  logic       out_last_q, out_last_d;

  mem_wr_t    mem_wr;
  mem_rd_t    mem_rd;
  obj_entry_t rd_a;
  obj_entry_t rd_b;

  logic       acc;
  range_t     value;
  range_t     diff;
  logic       jump;
  logic       close_en;
  logic       do_close;
  logic       room;
  index_t     close_idx;
  count_t     n_after;
  index_t     last_end_now;
  logic       merged;
  count_t     k_next;
  count_t     addr_a;
  count_t     addr_b;

  lsgf_obj_mem u_obj_mem (
    .clk_i  (clk_i),
    .wr_i   (mem_wr),
    .rd_i   (mem_rd),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  assign sample_i.ready = (state_q == S_RUN);
  assign acc            = sample_i.valid && sample_i.ready;

  assign value = sample_i.no_return ? nr_q : sample_i.range_mm;
  assign diff  = (value >= prev_q) ? (value - prev_q) : (prev_q - value);
  assign jump  = (cnt_q != '0) && (diff >= thr_q);

  assign close_en  = ((state_q == S_RUN) && acc && jump) || (state_q == S_CLOSE);
  assign close_idx = (state_q == S_CLOSE) ? last_idx_q : (cnt_q - 1'b1);
  assign do_close  = close_en && rhr_q;
  assign room      = (obj_cnt_q < COUNT_W'(MAX_OBJECTS));

  assign mem_wr.we    = do_close && room;
  assign mem_wr.addr  = obj_cnt_q[SLOT_W-1:0];
  assign mem_wr.entry = '{rs_idx_q, rs_rng_q, close_idx, prev_q};

  assign n_after      = obj_cnt_q + COUNT_W'(mem_wr.we);
  assign last_end_now = mem_wr.we ? last_idx_q : last_end_q;
  assign merged       = (n_after >= COUNT_W'(2)) && (first_start_q <= wst_q)
                        && (last_end_now >= wen_q);

  assign k_next = em_k_q + 1'b1;
  assign addr_a = em_k_q + COUNT_W'(em_base_q);
  assign addr_b = (k_next == em_n_q) ? COUNT_W'(em_base_q) : (k_next + COUNT_W'(em_base_q));

  assign mem_rd.en     = (state_q == S_EMIT) && (!out_valid_q || gap_o.ready)
                         && (em_n_q != '0);
  assign mem_rd.addr_a = addr_a[SLOT_W-1:0];
  assign mem_rd.addr_b = addr_b[SLOT_W-1:0];

  always_comb begin
    state_d         = state_q;
    thr_d           = thr_q;
    nr_d            = nr_q;
    wst_d           = wst_q;
    wen_d           = wen_q;
    cnt_d           = cnt_q;
    prev_d          = prev_q;
    rs_idx_d        = rs_idx_q;
    rs_rng_d        = rs_rng_q;
    rhr_d           = rhr_q;
    obj_cnt_d       = obj_cnt_q;
    ovf_d           = ovf_q;
    last_idx_d      = last_idx_q;
    first_start_d   = first_start_q;
    first_end_idx_d = first_end_idx_q;
    first_end_rng_d = first_end_rng_q;
    last_end_d      = last_end_q;
    em_n_d          = em_n_q;
    em_k_d          = em_k_q;
    em_base_d       = em_base_q;
    em_ovf_d        = em_ovf_q;
    em_merge_d      = em_merge_q;
    sub_d           = sub_q;
    out_valid_d     = out_valid_q && !gap_o.ready;
    out_d           = out_q;
    out_noobj_d     = out_noobj_q;
    out_ovf_d       = out_ovf_q;
    out_last_d      = out_last_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_JUMP_THRESHOLD: thr_d = cfg_data_i;
        CFG_NO_RETURN:      nr_d  = cfg_data_i;
        CFG_WRAP_START:     wst_d = cfg_data_i[9:0];
        CFG_WRAP_END:       wen_d = cfg_data_i[9:0];
        default:            thr_d = thr_q;
      endcase
    end

    // table bookkeeping for a closed object run
    if (do_close) begin
      if (room) begin
        obj_cnt_d  = obj_cnt_q + 1'b1;
        last_end_d = close_idx;
        if (obj_cnt_q == '0) begin
          first_start_d   = rs_idx_q;
          first_end_idx_d = close_idx;
          first_end_rng_d = prev_q;
        end
      end else begin
        ovf_d = 1'b1;
      end
    end

    unique case (state_q)
      S_RUN: begin
        if (acc) begin
          if (cnt_q == '0) begin
            rs_idx_d = '0;
            rs_rng_d = value;
            rhr_d    = (value < nr_q);
          end else if (jump) begin
            rs_idx_d = cnt_q;
            rs_rng_d = value;
            rhr_d    = (value < nr_q);
          end else if (value < nr_q) begin
            rhr_d = 1'b1;
          end
          prev_d = value;
          if (cnt_q != INDEX_W'(MAX_SAMPLES - 1)) begin
            cnt_d = cnt_q + 1'b1;
          end
          if (sample_i.last_sample) begin
            last_idx_d = cnt_q;
            state_d    = S_CLOSE;
          end
        end
      end
      S_CLOSE: begin
        em_n_d     = n_after - COUNT_W'(merged);
        em_base_d  = merged;
        em_merge_d = merged;
        em_ovf_d   = ovf_q || (do_close && !room);
        em_k_d     = '0;
        cnt_d      = '0;
        obj_cnt_d  = '0;
        ovf_d      = 1'b0;
        rhr_d      = 1'b0;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || gap_o.ready) begin
          sub_d     = em_merge_q && (k_next == em_n_q);
          state_d   = S_LOAD;
        end
      end
      S_LOAD: begin
        out_valid_d = 1'b1;
        out_ovf_d   = em_ovf_q;
        if (em_n_q == '0) begin
          out_d       = '0;
          out_noobj_d = 1'b1;
          out_last_d  = 1'b1;
          state_d     = S_RUN;
        end else begin
          // merged wrap object takes the end of the first object
          out_d.end_idx   = sub_q ? first_end_idx_q : rd_a.end_idx;
          out_d.end_rng   = sub_q ? first_end_rng_q : rd_a.end_rng;
          out_d.start_idx = rd_b.start_idx;
          out_d.start_rng = rd_b.start_rng;
          out_noobj_d     = 1'b0;
          out_last_d      = (k_next == em_n_q);
          em_k_d          = k_next;
          state_d         = (k_next == em_n_q) ? S_RUN : S_EMIT;
        end
      end
      default: state_d = S_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_RUN;
      thr_q           <= RST_JUMP_THRESHOLD;
      nr_q            <= RST_NO_RETURN;
      wst_q           <= RST_WRAP_START;
      wen_q           <= RST_WRAP_END;
      cnt_q           <= '0;
      prev_q          <= '0;
      rs_idx_q        <= '0;
      rs_rng_q        <= '0;
      rhr_q           <= 1'b0;
      obj_cnt_q       <= '0;
      ovf_q           <= 1'b0;
      last_idx_q      <= '0;
      first_start_q   <= '0;
      first_end_idx_q <= '0;
      first_end_rng_q <= '0;
      last_end_q      <= '0;
      em_n_q          <= '0;
      em_k_q          <= '0;
      em_base_q       <= 1'b0;
      em_ovf_q        <= 1'b0;
      em_merge_q      <= 1'b0;
      sub_q           <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      thr_q           <= thr_d;
      nr_q            <= nr_d;
      wst_q           <= wst_d;
      wen_q           <= wen_d;
      cnt_q           <= cnt_d;
      prev_q          <= prev_d;
      rs_idx_q        <= rs_idx_d;
      rs_rng_q        <= rs_rng_d;
      rhr_q           <= rhr_d;
      obj_cnt_q       <= obj_cnt_d;
      ovf_q           <= ovf_d;
      last_idx_q      <= last_idx_d;
      first_start_q   <= first_start_d;
      first_end_idx_q <= first_end_idx_d;
      first_end_rng_q <= first_end_rng_d;
      last_end_q      <= last_end_d;
      em_n_q          <= em_n_d;
      em_k_q          <= em_k_d;
      em_base_q       <= em_base_d;
      em_ovf_q        <= em_ovf_d;
      em_merge_q      <= em_merge_d;
      sub_q           <= sub_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q       <= out_d;
    out_noobj_q <= out_noobj_d;
    out_ovf_q   <= out_ovf_d;
    out_last_q  <= out_last_d;
  end

  assign gap_o.valid              = out_valid_q;
  assign gap_o.gap_start_index    = out_q.end_idx[9:0];
  assign gap_o.gap_start_range_mm = out_q.end_rng;
  assign gap_o.gap_end_index      = out_q.start_idx[9:0];
  assign gap_o.gap_end_range_mm   = out_q.start_rng;
  assign gap_o.no_objects         = out_noobj_q;
  assign gap_o.table_overflow     = out_ovf_q;
  assign gap_o.last_gap           = out_last_q;

  `LSGF_ASSERT(a_obj_cnt_bound, obj_cnt_q <= COUNT_W'(MAX_OBJECTS), "object count past table")
  `LSGF_ASSERT(a_last_closes, (acc && sample_i.last_sample) |=> (state_q == S_CLOSE), "final run not closed")
  `LSGF_ASSERT(a_no_wr_emit, (state_q == S_EMIT || state_q == S_LOAD) |-> !mem_wr.we, "table write during output")
  `LSGF_ASSERT(a_noobj_last, (gap_o.valid && gap_o.no_objects) |-> gap_o.last_gap, "empty scan word not final")
  `LSGF_ASSERT(a_emit_in_range, (state_q == S_LOAD && em_n_q != '0) |-> (em_k_q < em_n_q), "gap index past count")

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the laser scan gap finder: scans in, gap words checked
`timescale 1ns / 1ps

module testbench;
  import lsgf_pkg::*;

  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANGE_MAX     = 131071;

  typedef struct packed {
    logic [9:0] start_index;
    range_t     start_range;
    logic [9:0] end_index;
    range_t     end_range;
    logic       no_objects;
    logic       overflow;
    logic       last;
  } gap_word_t;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  lsgf_sample_if sample_if ();
  lsgf_gap_if    gap_if ();

  laser_scan_gap_finder DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .sample_i(sample_if),
    .gap_o   (gap_if)
  );

  // register shadow
  range_t     jump_mm     = RST_JUMP_THRESHOLD;
  range_t     nr_value_mm = RST_NO_RETURN;
  logic [9:0] wrap_start  = RST_WRAP_START;
  logic [9:0] wrap_end    = RST_WRAP_END;

  // segmentation state of the scan in progress
  int         scan_pos       = 0;
  range_t     prev_range     = '0;
  int         run_first_idx  = 0;
  range_t     run_first_rng  = '0;
  logic       run_returned   = 1'b0;
  obj_entry_t objects [MAX_OBJECTS];
  int         object_total   = 0;
  logic       table_full     = 1'b0;

  gap_word_t  gaps_due [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int cycle_count   = 0;
  int mismatches    = 0;
  int samples_sent  = 0;
  int scans_done    = 0;
  int gaps_checked  = 0;
  int empty_scans   = 0;
  int wrap_merges   = 0;
  int overflow_scans = 0;

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void open_run(int idx, range_t v);
    run_first_idx = idx;
    run_first_rng = v;
    run_returned  = (v < nr_value_mm);
  endfunction

  function automatic void close_run(int idx, range_t v);
    if (!run_returned) return;
    if (object_total < MAX_OBJECTS) begin
      objects[object_total].start_idx = index_t'(run_first_idx);
      objects[object_total].start_rng = run_first_rng;
      objects[object_total].end_idx   = index_t'(idx);
      objects[object_total].end_rng   = v;
      object_total++;
    end else begin
      table_full = 1'b1;
    end
  endfunction

  // follows one accepted sample, queues the gap words of a finished scan
  function automatic void track_sample(range_t r, logic nr, logic last);
    range_t    v;
    range_t    diff;
    int        idx;
    int        n;
    int        base;
    int        k;
    gap_word_t w;
    v   = nr ? nr_value_mm : r;
    idx = scan_pos;
    if (idx == 0) begin
      open_run(0, v);
    end else begin
      diff = (v >= prev_range) ? v - prev_range : prev_range - v;
      if (diff >= jump_mm) begin
        close_run(idx - 1, prev_range);
        open_run(idx, v);
      end else if (v < nr_value_mm) begin
        run_returned = 1'b1;
      end
    end
    prev_range = v;
    if (scan_pos < MAX_SAMPLES - 1) scan_pos++;
    if (!last) return;

    close_run(idx, v);
    n    = object_total;
    base = 0;
    if (n == 0) begin
      w            = '0;
      w.no_objects = 1'b1;
      w.overflow   = table_full;
      w.last       = 1'b1;
      gaps_due.insert(gaps_due.size(), w);
      empty_scans++;
    end else begin
      if (n >= 2 && objects[0].start_idx <= wrap_start && objects[n-1].end_idx >= wrap_end) begin
        objects[n-1].end_idx = objects[0].end_idx;
        objects[n-1].end_rng = objects[0].end_rng;
        base = 1;
        wrap_merges++;
      end
      n -= base;
      for (k = 0; k < n; k++) begin
        w.start_index = objects[base + k].end_idx;
        w.start_range = objects[base + k].end_rng;
        w.end_index   = objects[base + (k + 1) % n].start_idx;
        w.end_range   = objects[base + (k + 1) % n].start_rng;
        w.no_objects  = 1'b0;
        w.overflow    = table_full;
        w.last        = (k == n - 1);
        gaps_due.insert(gaps_due.size(), w);
      end
    end
    if (table_full) overflow_scans++;
    scan_pos     = 0;
    object_total = 0;
    table_full   = 1'b0;
    run_returned = 1'b0;
    scans_done++;
  endfunction

  function automatic int clamp_range(int v);
    if (v < 0) return 0;
    if (v > RANGE_MAX) return RANGE_MAX;
    return v;
  endfunction

  task automatic send_sample(range_t r, logic nr, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid       <= 1'b1;
    sample_if.range_mm    <= r;
    sample_if.no_return   <= nr;
    sample_if.last_sample <= last;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    track_sample(r, nr, last);
    samples_sent++;
  endtask

  task automatic drain_results();
    sample_if.valid <= 1'b0;
    while (gaps_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(int jump, int nr_mm, int ws, int we);
    logic [CFG_IDX_W-1:0] regs [4];
    int                   vals [4];
    int                   i;
    regs = '{CFG_JUMP_THRESHOLD, CFG_NO_RETURN, CFG_WRAP_START, CFG_WRAP_END};
    vals = '{jump, nr_mm, ws, we};
    drain_results();
    for (i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[i];
      cfg_data_i <= CFG_W'(vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i    <= 1'b0;
    jump_mm     = range_t'(jump);
    nr_value_mm = range_t'(nr_mm);
    wrap_start  = 10'(ws);
    wrap_end    = 10'(we);
  endtask

  // mostly runs of near-equal ranges split by jumps, some scans pure noise
  task automatic send_random_scan(int len);
    int   base;
    int   seg_left;
    int   span;
    int   v;
    int   i;
    logic nr_run;
    logic fresh;
    logic scramble;
    base     = $urandom_range(RANGE_MAX);
    seg_left = 0;
    nr_run   = 1'b0;
    fresh    = 1'b0;
    scramble = ($urandom_range(4) == 0);
    for (i = 0; i < len; i++) begin
      if (scramble) begin
        send_sample(range_t'($urandom), $urandom_range(7) == 0, i == len - 1);
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(1, 8);
          nr_run   = ($urandom_range(6) == 0);
          fresh    = 1'b1;
          case ($urandom_range(3))
            0: base = $urandom_range(1) ? base + int'(jump_mm) : base - int'(jump_mm);
            1: base = $urandom_range(1) ? base + int'(jump_mm) - 1 : base - int'(jump_mm) + 1;
            default: base = $urandom_range(1) ? int'($urandom_range(20000))
                                              : int'($urandom_range(RANGE_MAX));
          endcase
          base = clamp_range(base);
        end
        span = int'(jump_mm) / 2;
        v    = fresh ? base : clamp_range(base + int'($urandom_range(span)) - span / 2);
        send_sample(nr_run ? range_t'($urandom) : range_t'(v), nr_run, i == len - 1);
        fresh = 1'b0;
        seg_left--;
      end
    end
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // reset register values
    send_sample(17'd0, 1'b1, 1'b1);
    send_sample(17'd0, 1'b0, 1'b1);
    send_sample(17'd500, 1'b0, 1'b0);
    send_sample(17'd550, 1'b0, 1'b0);
    send_sample(17'd131071, 1'b0, 1'b0);
    send_sample(17'd1000, 1'b1, 1'b0);
    send_sample(17'd1000, 1'b0, 1'b0);
    send_sample(17'd1099, 1'b0, 1'b0);
    send_sample(17'd1199, 1'b0, 1'b0);
    send_sample(17'd0, 1'b0, 1'b1);
    // zero threshold, wrap merge across angle zero
    set_config(0, RANGE_MAX, 0, 0);
    send_sample(17'd7, 1'b0, 1'b0);
    send_sample(17'd7, 1'b0, 1'b0);
    send_sample(17'd9, 1'b0, 1'b1);
    // no sample can be below a zero no-return value
    set_config(RANGE_MAX, 0, 1023, 1023);
    send_sample(17'd0, 1'b0, 1'b0);
    send_sample(17'd131071, 1'b0, 1'b0);
    send_sample(17'd1, 1'b1, 1'b1);
    set_config(RANGE_MAX, RANGE_MAX, 1023, 0);
    send_sample(17'd0, 1'b0, 1'b0);
    send_sample(17'd131071, 1'b0, 1'b0);
    send_sample(17'd65535, 1'b0, 1'b1);
  endtask

  // scan longer than the index range, so the index saturates
  task automatic test_long_scan();
    int i;
    int seg;
    set_config(RST_JUMP_THRESHOLD, RST_NO_RETURN, RST_WRAP_START, RST_WRAP_END);
    send_idle_pct = 10;
    recv_idle_pct = 20;
    for (i = 0; i < 1040; i++) begin
      seg = (i < 1030) ? i / 40 : 26;
      send_sample(range_t'(((seg % 2) ? 8000 : 2000) + $urandom_range(40)),
                  (i % 97) == 50, i == 1039);
    end
  endtask

  // full object tables while the gap side is held off
  task automatic test_back_pressure();
    int s;
    int i;
    set_config(0, RANGE_MAX, 0, 1023);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    for (s = 0; s < 4; s++) begin
      for (i = 0; i < 40; i++) begin
        send_sample(range_t'($urandom_range(RANGE_MAX - 1)), 1'b0, i == 39);
      end
    end
    drain_results();
  endtask

  task automatic test_random(int items, int s_idle, int r_idle);
    int done;
    int phase_done;
    int len;
    int jump;
    int nr_mm;
    int ws;
    int we;
    done = 0;
    while (done < items) begin
      case ($urandom_range(7))
        0:       jump = 0;
        1:       jump = RANGE_MAX;
        2:       jump = 1;
        default: jump = $urandom_range(20, 4000);
      endcase
      case ($urandom_range(5))
        0:       nr_mm = 0;
        1:       nr_mm = RANGE_MAX;
        default: nr_mm = $urandom_range(60000, RANGE_MAX);
      endcase
      case ($urandom_range(3))
        0:       ws = 0;
        1:       ws = 1023;
        default: ws = $urandom_range(8);
      endcase
      case ($urandom_range(3))
        0:       we = 0;
        1:       we = 1023;
        default: we = $urandom_range(60);
      endcase
      set_config(jump, nr_mm, ws, we);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      phase_done = 0;
      while (phase_done < 60 && done < items) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
        send_random_scan(len);
        phase_done += len;
        done += len;
      end
    end
  endtask

  // gap side ready, with random stalls and the long hold-off
  initial begin
    int hold_left;
    hold_left    = 0;
    gap_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_served < hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (!rst_ni) begin
        gap_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        gap_if.ready <= 1'b0;
        hold_left--;
      end else begin
        gap_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic void check_field(string name, logic [16:0] want, logic [16:0] got);
    if (got !== want) begin
      $display("%0t mismatch in %s: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : gap_check
    gap_word_t want;
    if (rst_ni && gap_if.valid && gap_if.ready) begin
      if (gaps_due.size() == 0) begin
        $display("%0t unexpected gap word: expected none, actual %0d/%0d -> %0d/%0d",
                 $time, gap_if.gap_start_index, gap_if.gap_start_range_mm,
                 gap_if.gap_end_index, gap_if.gap_end_range_mm);
        mismatches++;
      end else begin
        want = gaps_due.pop_front();
        check_field("gap_start_index", want.start_index, gap_if.gap_start_index);
        check_field("gap_start_range_mm", want.start_range, gap_if.gap_start_range_mm);
        check_field("gap_end_index", want.end_index, gap_if.gap_end_index);
        check_field("gap_end_range_mm", want.end_range, gap_if.gap_end_range_mm);
        check_field("no_objects", want.no_objects, gap_if.no_objects);
        check_field("table_overflow", want.overflow, gap_if.table_overflow);
        check_field("last_gap", want.last, gap_if.last_gap);
        gaps_checked++;
      end
    end
  end

  initial begin
    sample_if.valid       = 1'b0;
    sample_if.range_mm    = '0;
    sample_if.no_return   = 1'b0;
    sample_if.last_sample = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_long_scan();
    test_back_pressure();
    test_random(170, 30, 49);
    test_random(170, 49, 30);
    test_random(170, 0, 0);
    drain_results();

    $display("covered %0d scans of %0d samples in total, %0d gap words compared",
             scans_done, samples_sent, gaps_checked);
    $display("including %0d empty scans, %0d wrap merges and %0d table overflows",
             empty_scans, wrap_merges, overflow_scans);
    if (mismatches == 0 && gaps_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
